/* rtl/assert_macros.svh */
// Assertion macros shared by the boot fallback decision RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ABFD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

`define ABFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ABFD_ASSERT(lbl, clk, rstn, prop)

`define ABFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/abfd_pkg.sv */
// Types, codes and helpers for the boot fallback decision block.
package abfd_pkg;

	localparam logic [2:0] ST_ERROR       = 3'd0;
	localparam logic [2:0] ST_ARM_REQ     = 3'd1;
	localparam logic [2:0] ST_ARMED       = 3'd2;
	localparam logic [2:0] ST_TESTING     = 3'd3;
	localparam logic [2:0] ST_RB_REQ      = 3'd4;
	localparam logic [2:0] ST_RB_ARMED    = 3'd5;
	localparam logic [2:0] ST_ROLLED_BACK = 3'd6;
	localparam logic [2:0] ST_OTHER       = 3'd7;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MISMATCH = 3'd1;
	localparam logic [2:0] ERR_ATTEMPTS = 3'd2;
	localparam logic [2:0] ERR_LOG_FULL = 3'd3;
	localparam logic [2:0] ERR_ARM_FAIL = 3'd4;

	localparam logic [1:0] ARM_NONE     = 2'd0;
	localparam logic [1:0] ARM_PRIOR    = 2'd1;
	localparam logic [1:0] ARM_PREVIOUS = 2'd2;

	localparam logic [1:0] OUTCOME_OK       = 2'd0;
	localparam logic [1:0] OUTCOME_NO_FREE  = 2'd1;
	localparam logic [1:0] OUTCOME_FAIL     = 2'd2;
	localparam logic [1:0] OUTCOME_RESERVED = 2'd3;

	localparam logic [7:0]  ATTEMPT_MAX = 8'hFF;
	localparam logic [15:0] NO_ENTRY    = 16'hFFFF;
	localparam logic [7:0]  MIN_LIMIT   = 8'd1;

	typedef struct packed {
		logic [2:0]  meta_state;
		logic        reason_is_attempts;
		logic [7:0]  prior_bank;
		logic [7:0]  target_bank;
		logic [7:0]  running_bank;
		logic [7:0]  attempt_count;
		logic [7:0]  attempt_limit;
		logic [1:0]  swap_outcome;
		logic [7:0]  other_bank;
		logic [15:0] stored_swap_entry;
		logic [15:0] new_swap_entry;
	} rec_t;

	typedef struct packed {
		logic [2:0]  next_state;
		logic [7:0]  next_target_bank;
		logic [7:0]  next_attempt_count;
		logic [7:0]  next_attempt_limit;
		logic [2:0]  error_update;
		logic        set_reason_attempts;
		logic [15:0] next_swap_entry;
		logic [1:0]  arm_request;
		logic        write_record;
	} dec_t;

	function automatic logic bank_known(input logic [7:0] b);
		return b[7:1] == 7'd0;
	endfunction

endpackage

/* rtl/abfd_decide.sv */
// Decision logic: one stored record in, one updated record out.
module abfd_decide (
	input  abfd_pkg::rec_t rec,
	output abfd_pkg::dec_t dec
);
	import abfd_pkg::*;

	logic       run_k;
	logic       tgt_k;
	logic       prior_at_run;
	logic       act;
	logic       rb;
	logic [7:0] limit;
	logic [7:0] count_inc;
	logic [7:0] rt;

	assign run_k        = bank_known(rec.running_bank);
	assign tgt_k        = bank_known(rec.target_bank);
	assign prior_at_run = bank_known(rec.prior_bank) && run_k
		&& (rec.prior_bank == rec.running_bank);
	assign limit        = (rec.attempt_limit == 8'd0) ? MIN_LIMIT : rec.attempt_limit;
	assign count_inc    = (rec.attempt_count != ATTEMPT_MAX) ?
		rec.attempt_count + 8'd1 : rec.attempt_count;
	assign act = rec.meta_state inside {ST_ARM_REQ, ST_ARMED, ST_TESTING};
	assign rb  = rec.meta_state inside {ST_RB_REQ, ST_RB_ARMED};

	always_comb begin
		dec.next_state          = rec.meta_state;
		dec.next_target_bank    = rec.target_bank;
		dec.next_attempt_count  = rec.attempt_count;
		dec.next_attempt_limit  = limit;
		dec.error_update        = ERR_NONE;
		dec.set_reason_attempts = 1'b0;
		dec.next_swap_entry     = rec.stored_swap_entry;
		dec.arm_request         = ARM_NONE;
		dec.write_record        = 1'b0;
		rt                      = rec.other_bank;

		if (rec.meta_state == ST_ERROR && rec.reason_is_attempts && prior_at_run) begin
			dec.next_target_bank = rec.prior_bank;
			dec.next_state       = ST_ROLLED_BACK;
			dec.write_record     = 1'b1;
		end else if (rb) begin
			if (run_k && ((tgt_k && rec.target_bank == rec.running_bank) || prior_at_run)) begin
				if (prior_at_run) begin
					dec.next_target_bank = rec.prior_bank;
				end
				dec.next_state   = ST_ROLLED_BACK;
				dec.write_record = 1'b1;
			end else if (rec.meta_state == ST_RB_ARMED) begin
				dec.next_state   = ST_ERROR;
				dec.error_update = ERR_MISMATCH;
				dec.write_record = 1'b1;
			end
		end else if (act) begin
			if (rec.meta_state == ST_ARM_REQ && tgt_k && run_k
					&& rec.target_bank != rec.running_bank) begin
				// hold pending arm request
			end else if (!tgt_k || !run_k) begin
				dec.next_state   = ST_ERROR;
				dec.error_update = ERR_MISMATCH;
				dec.write_record = 1'b1;
			end else begin
				dec.next_attempt_count = count_inc;
				dec.write_record       = 1'b1;
				if (rec.target_bank != rec.running_bank) begin
					dec.next_state   = ST_ERROR;
					dec.error_update = ERR_MISMATCH;
				end else if (count_inc > limit) begin
					dec.set_reason_attempts = 1'b1;
					dec.error_update        = ERR_ATTEMPTS;
					if (bank_known(rec.prior_bank) && rec.prior_bank != rec.running_bank) begin
						dec.arm_request = ARM_PRIOR;
						rt              = rec.prior_bank;
					end else begin
						dec.arm_request = ARM_PREVIOUS;
						rt              = rec.other_bank;
					end
					if (rec.swap_outcome == OUTCOME_OK) begin
						dec.next_state = ST_RB_ARMED;
						if (bank_known(rt)) begin
							dec.next_target_bank = rt;
						end
						if (rec.new_swap_entry != NO_ENTRY) begin
							dec.next_swap_entry = rec.new_swap_entry;
						end
					end else begin
						dec.next_state   = ST_ERROR;
						dec.error_update = (rec.swap_outcome == OUTCOME_NO_FREE) ?
							ERR_LOG_FULL : ERR_ARM_FAIL;
					end
				end else begin
					dec.next_state = ST_TESTING;
				end
			end
		end
	end

endmodule

/* rtl/ab_boot_fallback_decision_top.sv */
// Top level of the A/B boot fallback decision block: input and result registers.
// One stored update record enters per item and yields exactly one decision item,
// offered once it has passed the input register and then the result register; a new
// record is accepted every cycle while dec_ready does not hold the output, since the whole
// decision is a single combinational pass between the input register and the
// result register, and the input register takes a record only when empty or when the result register advances.
// The block holds no state between items.
`include "assert_macros.svh"

module ab_boot_fallback_decision_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	output logic           rec_ready,
	input  abfd_pkg::rec_t rec,
	output logic           dec_valid,
	input  logic           dec_ready,
	output abfd_pkg::dec_t dec
);
	import abfd_pkg::*;

	logic valid_s1;
	logic valid_s2;
	logic adv_s2;
	rec_t rec_s1;
	dec_t dec_comb;
	dec_t dec_s2;

	assign adv_s2    = !valid_s2 || dec_ready;
	assign rec_ready = !valid_s1 || adv_s2;
	assign dec_valid = valid_s2;
	assign dec       = dec_s2;

	abfd_decide u_decide (
		.rec (rec_s1),
		.dec (dec_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rec_valid && rec_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready) begin
			rec_s1 <= rec;
		end
		if (valid_s1 && adv_s2) begin
			dec_s2 <= dec_comb;
		end
	end

	`ABFD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, rec_valid && rec_ready, valid_s1)
	`ABFD_ASSERT(a_quiet_without_write, clk, arst_n, !(dec_valid && !dec.write_record) || (dec.error_update == ERR_NONE && dec.arm_request == ARM_NONE && !dec.set_reason_attempts))
	`ABFD_ASSERT(a_limit_nonzero, clk, arst_n, !dec_valid || dec.next_attempt_limit != 8'd0)
	`ABFD_ASSERT(a_arm_implies_reason, clk, arst_n, !dec_valid || ((dec.arm_request != ARM_NONE) == dec.set_reason_attempts))
	`ABFD_ASSERT(a_arm_outcome_state, clk, arst_n, !(dec_valid && dec.arm_request != ARM_NONE) || dec.next_state == ST_RB_ARMED || dec.next_state == ST_ERROR)
	`ABFD_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && adv_s2, valid_s2)

endmodule

/* tb/sv/abfd_checker.sv */
// Checker for the boot fallback decision block: predicts each decision and compares it.
`timescale 1ns / 100ps

module abfd_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  logic           rec_ready,
	input  abfd_pkg::rec_t rec,
	input  logic           dec_valid,
	input  logic           dec_ready,
	input  abfd_pkg::dec_t dec,
	output int             fail_count,
	output int             pending,
	output int             checked,
	output int             armed_count
);
	import abfd_pkg::*;

	dec_t exp_dec_q[$];

	function automatic logic is_known_bank(input logic [7:0] b);
		return b < 8'd2;
	endfunction

	function automatic dec_t predict_decision(input rec_t r);
		dec_t       d;
		logic [2:0] st;
		logic [7:0] tgt;
		logic [7:0] cnt;
		logic [7:0] lim;
		logic [7:0] rb_bank;
		logic [15:0] ent;
		logic [2:0] err;
		logic [1:0] arm;
		logic       reas;
		logic       wr;
		logic       run_k;
		logic       tgt_k;
		logic       prior_at_run;
		st = r.meta_state;
		tgt = r.target_bank;
		cnt = r.attempt_count;
		lim = (r.attempt_limit == 8'd0) ? MIN_LIMIT : r.attempt_limit;
		ent = r.stored_swap_entry;
		err = ERR_NONE;
		arm = ARM_NONE;
		reas = 1'b0;
		wr = 1'b0;
		run_k = is_known_bank(r.running_bank);
		tgt_k = is_known_bank(r.target_bank);
		prior_at_run = is_known_bank(r.prior_bank) && run_k && r.prior_bank == r.running_bank;
		if (st == ST_ERROR && r.reason_is_attempts && prior_at_run) begin
			tgt = r.prior_bank;
			st = ST_ROLLED_BACK;
			wr = 1'b1;
		end else if (st == ST_RB_REQ || st == ST_RB_ARMED) begin
			if (run_k && ((tgt_k && r.target_bank == r.running_bank) || prior_at_run)) begin
				if (prior_at_run)
					tgt = r.prior_bank;
				st = ST_ROLLED_BACK;
				wr = 1'b1;
			end else if (st == ST_RB_ARMED) begin
				st = ST_ERROR;
				err = ERR_MISMATCH;
				wr = 1'b1;
			end
		end else if (st == ST_ARM_REQ || st == ST_ARMED || st == ST_TESTING) begin
			if (st == ST_ARM_REQ && tgt_k && run_k && r.target_bank != r.running_bank) begin
				// hold the pending request
			end else if (!tgt_k || !run_k) begin
				st = ST_ERROR;
				err = ERR_MISMATCH;
				wr = 1'b1;
			end else begin
				if (cnt < ATTEMPT_MAX)
					cnt = cnt + 8'd1;
				wr = 1'b1;
				if (r.target_bank != r.running_bank) begin
					st = ST_ERROR;
					err = ERR_MISMATCH;
				end else if (cnt > lim) begin
					reas = 1'b1;
					err = ERR_ATTEMPTS;
					if (is_known_bank(r.prior_bank) && r.prior_bank != r.running_bank) begin
						arm = ARM_PRIOR;
						rb_bank = r.prior_bank;
					end else begin
						arm = ARM_PREVIOUS;
						rb_bank = r.other_bank;
					end
					if (r.swap_outcome == OUTCOME_OK) begin
						st = ST_RB_ARMED;
						if (is_known_bank(rb_bank))
							tgt = rb_bank;
						if (r.new_swap_entry != NO_ENTRY)
							ent = r.new_swap_entry;
					end else begin
						st = ST_ERROR;
						err = (r.swap_outcome == OUTCOME_NO_FREE) ? ERR_LOG_FULL : ERR_ARM_FAIL;
					end
				end else begin
					st = ST_TESTING;
				end
			end
		end
		d.next_state = st;
		d.next_target_bank = tgt;
		d.next_attempt_count = cnt;
		d.next_attempt_limit = lim;
		d.error_update = err;
		d.set_reason_attempts = reas;
		d.next_swap_entry = ent;
		d.arm_request = arm;
		d.write_record = wr;
		return d;
	endfunction

	always @(posedge clk) begin
		dec_t want;
		if (arst_n) begin
			if (rec_valid && rec_ready) begin
				want = predict_decision(rec);
				exp_dec_q.push_back(want);
				if (want.arm_request != ARM_NONE)
					armed_count = armed_count + 1;
			end
			if (dec_valid && dec_ready) begin
				if (exp_dec_q.size() == 0) begin
					$error("decision item with no record waiting: %h", dec);
					fail_count = fail_count + 1;
				end else begin
					want = exp_dec_q.pop_front();
					checked = checked + 1;
					if (dec.next_state !== want.next_state) begin
						$error("next_state: expected %0d, got %0d", want.next_state,
							dec.next_state);
						fail_count = fail_count + 1;
					end
					if (dec.next_target_bank !== want.next_target_bank) begin
						$error("next_target_bank: expected %0d, got %0d",
							want.next_target_bank, dec.next_target_bank);
						fail_count = fail_count + 1;
					end
					if (dec.next_attempt_count !== want.next_attempt_count) begin
						$error("next_attempt_count: expected %0d, got %0d",
							want.next_attempt_count, dec.next_attempt_count);
						fail_count = fail_count + 1;
					end
					if (dec.next_attempt_limit !== want.next_attempt_limit) begin
						$error("next_attempt_limit: expected %0d, got %0d",
							want.next_attempt_limit, dec.next_attempt_limit);
						fail_count = fail_count + 1;
					end
					if (dec.error_update !== want.error_update) begin
						$error("error_update: expected %0d, got %0d", want.error_update,
							dec.error_update);
						fail_count = fail_count + 1;
					end
					if (dec.set_reason_attempts !== want.set_reason_attempts) begin
						$error("set_reason_attempts: expected %0d, got %0d",
							want.set_reason_attempts, dec.set_reason_attempts);
						fail_count = fail_count + 1;
					end
					if (dec.next_swap_entry !== want.next_swap_entry) begin
						$error("next_swap_entry: expected %0d, got %0d",
							want.next_swap_entry, dec.next_swap_entry);
						fail_count = fail_count + 1;
					end
					if (dec.arm_request !== want.arm_request) begin
						$error("arm_request: expected %0d, got %0d", want.arm_request,
							dec.arm_request);
						fail_count = fail_count + 1;
					end
					if (dec.write_record !== want.write_record) begin
						$error("write_record: expected %0d, got %0d", want.write_record,
							dec.write_record);
						fail_count = fail_count + 1;
					end
				end
			end
			pending = exp_dec_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top: drives update records into the boot fallback decision block and gives the verdict.
`timescale 1ns / 100ps

module tb;
	import abfd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic rec_valid;
	logic rec_ready;
	rec_t rec;
	logic dec_valid;
	logic dec_ready = 1'b0;
	dec_t dec;

	int fail_count;
	int pending;
	int checked;
	int armed_count;

	int sent = 0;
	int burst_left = 0;
	int rdy_left = 0;
	int rdy_mode = 0;
	logic [2:0] rdy_phase = 3'd0;

	always #1 clk = ~clk;

	ab_boot_fallback_decision_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec)
	);

	abfd_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (rec_valid),
		.rec_ready   (rec_ready),
		.rec         (rec),
		.dec_valid   (dec_valid),
		.dec_ready   (dec_ready),
		.dec         (dec),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.armed_count (armed_count)
	);

	always @(posedge clk) begin
		rdy_phase <= rdy_phase + 3'd1;
		if (rdy_left == 0) begin
			rdy_mode <= $urandom_range(0, 3);
			rdy_left <= $urandom_range(16, 96);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_mode)
			0: dec_ready <= 1'b1;
			1: dec_ready <= ($urandom_range(0, 3) != 0);
			2: dec_ready <= ($urandom_range(0, 3) == 0);
			default: dec_ready <= (rdy_phase < 3'd3);
		endcase
	end

	function automatic logic [7:0] pick_bank();
		if ($urandom_range(0, 9) != 0)
			return 8'($urandom_range(0, 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic rec_t random_rec();
		rec_t        r;
		int          k;
		logic [31:0] rnd;
		r[31:0] = $urandom;
		r[63:32] = $urandom;
		rnd = $urandom;
		r[$bits(rec_t)-1:64] = rnd[$bits(rec_t)-65:0];
		if ($urandom_range(0, 9) < 3)
			return r;
		r.prior_bank = pick_bank();
		r.target_bank = pick_bank();
		r.running_bank = pick_bank();
		if ($urandom_range(0, 3) != 0)
			r.target_bank = r.running_bank;
		k = $urandom_range(0, 9);
		if (k < 2)
			r.attempt_limit = 8'd0;
		else if (k < 3)
			r.attempt_limit = 8'hFF;
		else if (k < 7)
			r.attempt_limit = 8'($urandom_range(1, 8));
		if ($urandom_range(0, 1) != 0)
			r.attempt_count = r.attempt_limit + 8'($urandom_range(0, 2)) - 8'd1;
		if ($urandom_range(0, 4) == 0)
			r.new_swap_entry = NO_ENTRY;
		r.other_bank = pick_bank();
		return r;
	endfunction

	task automatic send_rec(input rec_t r);
		if (burst_left == 0)
			burst_left = $urandom_range(1, 40);
		rec <= r;
		rec_valid <= 1'b1;
		@(posedge clk);
		while (!rec_ready)
			@(posedge clk);
		sent = sent + 1;
		burst_left = burst_left - 1;
		if (burst_left == 0) begin
			rec_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		rec_valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		rec_t base;
		rec_t r;
		arst_n = 1'b0;
		rec_valid = 1'b0;
		rec = '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		base = '0;
		base.meta_state = ST_ARMED;
		base.target_bank = 8'd1;
		base.running_bank = 8'd1;
		base.attempt_limit = 8'd3;
		base.swap_outcome = OUTCOME_OK;
		base.stored_swap_entry = 16'h0010;
		base.new_swap_entry = 16'h0020;
		for (int i = 0; i < 25; i++) begin
			r = base;
			case (i)
				1: begin
					r.meta_state = ST_ERROR;
					r.reason_is_attempts = 1'b1;
					r.prior_bank = 8'd1;
				end
				2: r.meta_state = ST_ERROR;
				3: r.meta_state = ST_ROLLED_BACK;
				4: r.meta_state = ST_OTHER;
				5: r.meta_state = ST_RB_REQ;
				6: begin
					r.meta_state = ST_RB_REQ;
					r.target_bank = 8'd0;
				end
				7: begin
					r.meta_state = ST_RB_ARMED;
					r.target_bank = 8'd0;
				end
				8: begin
					r.meta_state = ST_RB_ARMED;
					r.target_bank = 8'hFF;
					r.prior_bank = 8'd1;
				end
				9: begin
					r.meta_state = ST_ARM_REQ;
					r.target_bank = 8'd0;
				end
				10: begin
					r.meta_state = ST_ARM_REQ;
					r.target_bank = 8'h80;
				end
				11: begin
					r.meta_state = ST_TESTING;
					r.running_bank = 8'hFE;
				end
				12: begin
					r.meta_state = ST_TESTING;
					r.attempt_count = 8'd3;
				end
				13: begin
					r.attempt_count = 8'hFF;
					r.attempt_limit = 8'hFF;
				end
				14: r.attempt_limit = 8'd0;
				15: begin
					r.attempt_limit = 8'd0;
					r.attempt_count = 8'd1;
					r.prior_bank = 8'd1;
				end
				16: begin
					r.attempt_count = 8'd9;
					r.prior_bank = 8'd1;
					r.other_bank = 8'hAA;
				end
				17: begin
					r.attempt_count = 8'd9;
					r.swap_outcome = OUTCOME_NO_FREE;
				end
				18: begin
					r.attempt_count = 8'd9;
					r.swap_outcome = OUTCOME_FAIL;
				end
				19: begin
					r.attempt_count = 8'd9;
					r.swap_outcome = OUTCOME_RESERVED;
				end
				20: begin
					r.attempt_count = 8'd9;
					r.new_swap_entry = NO_ENTRY;
				end
				21: r.target_bank = 8'd0;
				22: r = '1;
				23: r = '0;
				24: begin
					r.attempt_count = 8'd9;
					r.prior_bank = 8'h55;
				end
				default: ;
			endcase
			send_rec(r);
		end
		drain();

		for (int i = 0; i < 1750; i++) begin
			send_rec(random_rec());
			if (i == 875)
				drain();
		end
		drain();
		repeat (8)
			@(posedge clk);

		$display("Summary: %0d records sent, %0d decisions compared, %0d of them arming a swap.",
			sent, checked, armed_count);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
